/* rtl/qsm_pkg.sv */
package qsm_pkg;

  typedef logic signed [31:0] val_t;
  typedef logic signed [65:0] wide_t;
  typedef logic [30:0] mag_t;
  // body_rate [47:0], target_rate [95:48], target_accel [143:96]
  typedef logic [143:0] rates_t;

  localparam int QUAT_LEN = 4;
  localparam int GAIN_FRAC = 12;
  localparam wide_t SAT_MAX = 66'sd2147483647;
  localparam wide_t RND_G = 66'sd2048;

  typedef enum logic [2:0] {
    REG_SURFACE_GAIN    = 3'd0,
    REG_REACH_GAIN      = 3'd1,
    REG_INV_BOUNDARY    = 3'd2,
    REG_SURFACE_DEADBAND = 3'd3,
    REG_TORQUE_LIMIT    = 3'd4,
    REG_INERTIA_DIAG    = 3'd5,
    REG_INERTIA_OFFDIAG = 3'd6
  } cfg_reg_t;

  function automatic val_t sat(input wide_t v);
    if (v > SAT_MAX) return val_t'(SAT_MAX);
    if (v < -SAT_MAX) return val_t'(-SAT_MAX);
    return val_t'(v);
  endfunction

  function automatic val_t sub2(input val_t a, input val_t b);
    return sat(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic val_t add2(input val_t a, input val_t b);
    return sat(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic val_t dbl(input val_t a);
    return sat(wide_t'(a) <<< 1);
  endfunction

  function automatic val_t neg_if(input logic n, input val_t a);
    return n ? -a : a;
  endfunction

  // unsigned Q4.12 gain times value, rounded, saturated
  function automatic val_t gmul(input logic [15:0] g, input val_t v);
    wide_t p;
    p = wide_t'({1'b0, g}) * wide_t'(v);
    return sat((p + RND_G) >>> GAIN_FRAC);
  endfunction

  // one inertia term, rounded, not saturated
  function automatic wide_t imt(input logic signed [16:0] m, input val_t v);
    wide_t p;
    p = wide_t'(m) * wide_t'(v);
    return (p + RND_G) >>> GAIN_FRAC;
  endfunction

  function automatic val_t sum3(input wide_t a, input wide_t b, input wide_t c);
    return sat(a + b + c);
  endfunction

  // cross product index helpers
  function automatic int nx1(input int j);
    return (j == 2) ? 0 : j + 1;
  endfunction

  function automatic int nx2(input int j);
    return (j == 0) ? 2 : j - 1;
  endfunction

endpackage

/* rtl/quaternion_sliding_mode_attitude_ctrl_core.sv */
// Pipeline stages from request accept to result: error product and norm 4, square root 32
//   (one root bit per stage), normalization 1, divider COMPONENT_WIDTH - 2 (one quotient bit
//   per stage), control law 11 plus output register.
// Throughput: one request per cycle; a held result freezes the whole pipeline.
// Reset (rst, synchronous): clears all pipeline valids and loads register defaults.
module quaternion_sliding_mode_attitude_ctrl_core #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // att_quat, body_rate, target_quat, target_rate, target_accel
  input  logic [271:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // torque_x, torque_y, torque_z, coast_mask, zero pad
  output logic [55:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  localparam int F  = COMPONENT_WIDTH - 3;
  localparam int QW = F + 1;
  localparam int NQ = qsm_pkg::QUAT_LEN;
  localparam int RW = $bits(qsm_pkg::rates_t);
  localparam int PW_SQ = NQ * $bits(qsm_pkg::mag_t) + NQ + RW;
  localparam int PW_DV = 1 + NQ + RW;
  localparam qsm_pkg::wide_t RND_Q = qsm_pkg::wide_t'(1) <<< (F - 1);
  localparam qsm_pkg::val_t ONE_Q = qsm_pkg::val_t'(1) <<< F;

  function automatic qsm_pkg::val_t comp(input logic [127:0] word, input int i);
    logic [COMPONENT_WIDTH-1:0] raw;
    raw = word[i*COMPONENT_WIDTH +: COMPONENT_WIDTH];
    return qsm_pkg::val_t'($signed(raw));
  endfunction

  function automatic qsm_pkg::val_t mulq(input qsm_pkg::val_t a, input qsm_pkg::val_t b);
    qsm_pkg::wide_t p;
    p = qsm_pkg::wide_t'(a) * qsm_pkg::wide_t'(b);
    return qsm_pkg::sat((p + RND_Q) >>> F);
  endfunction

  function automatic qsm_pkg::val_t clamp_one(input qsm_pkg::val_t x);
    if (x > ONE_Q) return ONE_Q;
    if (x < -ONE_Q) return -ONE_Q;
    return x;
  endfunction

  // configuration
  logic [15:0] surface_gain, reach_gain, inv_boundary, surface_deadband;
  logic [14:0] torque_limit;
  logic [47:0] inertia_diag, inertia_offdiag;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_gain     <= 16'd4096;
      reach_gain       <= 16'd4096;
      inv_boundary     <= 16'd4096;
      surface_deadband <= 16'd0;
      torque_limit     <= 15'h7fff;
      inertia_diag     <= 48'h1000_1000_1000;
      inertia_offdiag  <= 48'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        qsm_pkg::REG_SURFACE_GAIN:     surface_gain     <= cfg_data[15:0];
        qsm_pkg::REG_REACH_GAIN:       reach_gain       <= cfg_data[15:0];
        qsm_pkg::REG_INV_BOUNDARY:     inv_boundary     <= cfg_data[15:0];
        qsm_pkg::REG_SURFACE_DEADBAND: surface_deadband <= cfg_data[15:0];
        qsm_pkg::REG_TORQUE_LIMIT:     torque_limit     <= cfg_data[14:0];
        qsm_pkg::REG_INERTIA_DIAG:     inertia_diag     <= cfg_data;
        qsm_pkg::REG_INERTIA_OFFDIAG:  inertia_offdiag  <= cfg_data;
        default: ;
      endcase
    end
  end

  // symmetric inertia matrix
  logic signed [16:0] inert [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r == c) inert[r][c] = $signed({1'b0, inertia_diag[16*r +: 16]});
        else inert[r][c] = $signed(inertia_offdiag[16*(r+c-1) +: 16]);
      end
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // input components
  qsm_pkg::val_t in_q [NQ];
  qsm_pkg::val_t in_t [NQ];
  always_comb begin
    for (int i = 0; i < NQ; i++) begin
      in_q[i] = comp({64'd0, s_axis_tdata[63:0]}, i);
      in_t[i] = comp({64'd0, s_axis_tdata[175:112]}, i);
    end
  end

  // ---------------- error quaternion and norm ----------------
  logic v1, v2, v3, v4;
  qsm_pkg::val_t  p1 [NQ][NQ];
  qsm_pkg::rates_t r1, r2, r3, r4;
  qsm_pkg::mag_t  a2 [NQ];
  qsm_pkg::mag_t  a3 [NQ];
  qsm_pkg::mag_t  a4 [NQ];
  logic [NQ-1:0]  sg2, sg3, sg4;
  logic [61:0]    sq3 [NQ];
  logic [63:0]    n2_4;

  qsm_pkg::val_t e_val [NQ];
  always_comb begin
    e_val[0] = qsm_pkg::sat(qsm_pkg::wide_t'(p1[0][0]) + qsm_pkg::wide_t'(p1[0][1])
                          + qsm_pkg::wide_t'(p1[0][2]) + qsm_pkg::wide_t'(p1[0][3]));
    for (int i = 1; i < NQ; i++) begin
      e_val[i] = qsm_pkg::sat(qsm_pkg::wide_t'(p1[i][0]) - qsm_pkg::wide_t'(p1[i][1])
                            - qsm_pkg::wide_t'(p1[i][2]) + qsm_pkg::wide_t'(p1[i][3]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0][0] <= mulq(in_t[0], in_q[0]);
      p1[0][1] <= mulq(in_t[1], in_q[1]);
      p1[0][2] <= mulq(in_t[2], in_q[2]);
      p1[0][3] <= mulq(in_t[3], in_q[3]);
      p1[1][0] <= mulq(in_t[0], in_q[1]);
      p1[1][1] <= mulq(in_q[0], in_t[1]);
      p1[1][2] <= mulq(in_t[2], in_q[3]);
      p1[1][3] <= mulq(in_t[3], in_q[2]);
      p1[2][0] <= mulq(in_t[0], in_q[2]);
      p1[2][1] <= mulq(in_q[0], in_t[2]);
      p1[2][2] <= mulq(in_t[3], in_q[1]);
      p1[2][3] <= mulq(in_t[1], in_q[3]);
      p1[3][0] <= mulq(in_t[0], in_q[3]);
      p1[3][1] <= mulq(in_q[0], in_t[3]);
      p1[3][2] <= mulq(in_t[1], in_q[2]);
      p1[3][3] <= mulq(in_t[2], in_q[1]);
      r1 <= {s_axis_tdata[271:176], s_axis_tdata[111:64]};
      for (int i = 0; i < NQ; i++) begin
        a2[i]  <= qsm_pkg::mag_t'(e_val[i][31] ? -e_val[i] : e_val[i]);
        sg2[i] <= e_val[i][31];
        sq3[i] <= a2[i] * a2[i];
        a3[i]  <= a2[i];
        a4[i]  <= a3[i];
      end
      r2 <= r1;
      r3 <= r2;
      r4 <= r3;
      sg3 <= sg2;
      sg4 <= sg3;
      n2_4 <= 64'(sq3[0]) + 64'(sq3[1]) + 64'(sq3[2]) + 64'(sq3[3]);
    end
  end

  logic             sq_valid;
  logic [31:0]      sq_root;
  logic [PW_SQ-1:0] sq_pay;

  qsm_sqrt #(.PW(PW_SQ)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_rad    (n2_4),
    .in_pay    ({a4[3], a4[2], a4[1], a4[0], sg4, r4}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  // ---------------- normalization ----------------
  logic                      v5;
  logic [NQ-1:0][63:0]       num5;
  logic [31:0]               den5;
  logic                      zero5;
  logic [NQ-1:0]             sg5;
  qsm_pkg::rates_t           r5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NQ; i++) begin
        num5[i] <= (64'(sq_pay[RW + NQ + 31*i +: 31]) << F) + 64'(sq_root >> 1);
      end
      den5  <= sq_root;
      zero5 <= (sq_root == 32'd0);
      sg5   <= sq_pay[RW +: NQ];
      r5    <= sq_pay[RW-1:0];
    end
  end

  logic                     dv_valid;
  logic [NQ-1:0][QW-1:0]    dv_quot;
  logic [PW_DV-1:0]         dv_pay;

  qsm_div #(.QW(QW), .PW(PW_DV)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_num    (num5),
    .in_den    (den5),
    .in_pay    ({zero5, sg5, r5}),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_pay   (dv_pay)
  );

  // ---------------- control law ----------------
  logic vn, va, vb, vc, vd, ve, vf, vg, vh, vi, vj;

  qsm_pkg::val_t sn_n [NQ];
  logic          sn_neg;
  qsm_pkg::val_t sn_w [3], sn_wt [3], sn_wa [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NQ; i++) begin
        sn_n[i] <= dv_pay[RW + NQ] ? '0 :
                   qsm_pkg::neg_if(dv_pay[RW + i], qsm_pkg::val_t'(dv_quot[i]));
      end
      sn_neg <= !dv_pay[RW + NQ] && dv_pay[RW] && (dv_quot[0] != '0);
      for (int ax = 0; ax < 3; ax++) begin
        sn_w[ax]  <= comp({80'd0, dv_pay[47:0]}, ax);
        sn_wt[ax] <= comp({80'd0, dv_pay[95:48]}, ax);
        sn_wa[ax] <= comp({80'd0, dv_pay[143:96]}, ax);
      end
    end
  end

  qsm_pkg::val_t cu_n [3], cu_b [3];

  qsm_pkg::val_t  sa_xt [3][2], sa_xa [3][2], sa_lq [3];
  qsm_pkg::wide_t sa_iwp [3][3];
  qsm_pkg::val_t  sa_n [NQ], sa_w [3], sa_wt [3], sa_wa [3];
  logic           sa_neg;

  qsm_pkg::val_t  sb_tt [3], sb_ta [3], sb_lq [3], sb_iw [3];
  qsm_pkg::val_t  sb_n [NQ], sb_w [3], sb_wt [3], sb_wa [3];
  logic           sb_neg;

  qsm_pkg::val_t  sc_x2t [3][2], sc_x2a [3][2], sc_nt [3], sc_na [3], sc_g [3][2];
  qsm_pkg::val_t  sc_lq [3], sc_w [3], sc_wt [3], sc_wa [3], sc_n [NQ];
  logic           sc_neg;

  qsm_pkg::val_t  sd_wtb [3], sd_wab [3], sd_gyro [3], sd_lq [3], sd_w [3], sd_n [NQ];
  logic           sd_neg;

  qsm_pkg::val_t  se_we [3], se_lq [3], se_wtb [3], se_wab [3], se_gyro [3], se_n [NQ];
  logic           se_neg;

  qsm_pkg::val_t  sf_s [3], sf_nw [3], sf_xc [3][2], sf_xf [3][2], sf_wab [3], sf_gyro [3];
  logic           sf_neg;

  qsm_pkg::val_t  sg_qd [3], sg_ffv [3], sg_x [3], sg_s [3], sg_gyro [3];
  logic           sg_neg;

  qsm_pkg::val_t  sh_eqv [3], sh_r [3], sh_s [3], sh_gyro [3];
  qsm_pkg::wide_t sh_ffp [3][3];

  qsm_pkg::val_t  si_ff [3], si_s [3], si_gyro [3];
  qsm_pkg::wide_t si_eqp [3][3], si_rp [3][3];

  qsm_pkg::val_t  sj_eq [3], sj_reach [3], sj_ff [3], sj_s [3], sj_gyro [3];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      cu_n[ax] = -sn_n[ax+1];
      cu_b[ax] = -sb_n[ax+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // rotation cross products, lambda*q_v, I*w terms
      for (int ax = 0; ax < 3; ax++) begin
        sa_xt[ax][0] <= mulq(cu_n[qsm_pkg::nx1(ax)], sn_wt[qsm_pkg::nx2(ax)]);
        sa_xt[ax][1] <= mulq(cu_n[qsm_pkg::nx2(ax)], sn_wt[qsm_pkg::nx1(ax)]);
        sa_xa[ax][0] <= mulq(cu_n[qsm_pkg::nx1(ax)], sn_wa[qsm_pkg::nx2(ax)]);
        sa_xa[ax][1] <= mulq(cu_n[qsm_pkg::nx2(ax)], sn_wa[qsm_pkg::nx1(ax)]);
        sa_lq[ax] <= qsm_pkg::gmul(surface_gain, sn_n[ax+1]);
        for (int k = 0; k < 3; k++) sa_iwp[ax][k] <= qsm_pkg::imt(inert[ax][k], sn_w[k]);
        sa_w[ax]  <= sn_w[ax];
        sa_wt[ax] <= sn_wt[ax];
        sa_wa[ax] <= sn_wa[ax];
      end
      for (int i = 0; i < NQ; i++) sa_n[i] <= sn_n[i];
      sa_neg <= sn_neg;

      // t = 2 (cu x v), signed lambda*q_v, I*w
      for (int ax = 0; ax < 3; ax++) begin
        sb_tt[ax] <= qsm_pkg::dbl(qsm_pkg::sub2(sa_xt[ax][0], sa_xt[ax][1]));
        sb_ta[ax] <= qsm_pkg::dbl(qsm_pkg::sub2(sa_xa[ax][0], sa_xa[ax][1]));
        sb_lq[ax] <= qsm_pkg::neg_if(sa_neg, sa_lq[ax]);
        sb_iw[ax] <= qsm_pkg::sum3(sa_iwp[ax][0], sa_iwp[ax][1], sa_iwp[ax][2]);
        sb_w[ax]  <= sa_w[ax];
        sb_wt[ax] <= sa_wt[ax];
        sb_wa[ax] <= sa_wa[ax];
      end
      for (int i = 0; i < NQ; i++) sb_n[i] <= sa_n[i];
      sb_neg <= sa_neg;

      // cu x t, n0*t, gyroscopic cross products
      for (int ax = 0; ax < 3; ax++) begin
        sc_x2t[ax][0] <= mulq(cu_b[qsm_pkg::nx1(ax)], sb_tt[qsm_pkg::nx2(ax)]);
        sc_x2t[ax][1] <= mulq(cu_b[qsm_pkg::nx2(ax)], sb_tt[qsm_pkg::nx1(ax)]);
        sc_x2a[ax][0] <= mulq(cu_b[qsm_pkg::nx1(ax)], sb_ta[qsm_pkg::nx2(ax)]);
        sc_x2a[ax][1] <= mulq(cu_b[qsm_pkg::nx2(ax)], sb_ta[qsm_pkg::nx1(ax)]);
        sc_nt[ax] <= mulq(sb_n[0], sb_tt[ax]);
        sc_na[ax] <= mulq(sb_n[0], sb_ta[ax]);
        sc_g[ax][0] <= mulq(sb_w[qsm_pkg::nx1(ax)], sb_iw[qsm_pkg::nx2(ax)]);
        sc_g[ax][1] <= mulq(sb_w[qsm_pkg::nx2(ax)], sb_iw[qsm_pkg::nx1(ax)]);
        sc_lq[ax] <= sb_lq[ax];
        sc_w[ax]  <= sb_w[ax];
        sc_wt[ax] <= sb_wt[ax];
        sc_wa[ax] <= sb_wa[ax];
      end
      for (int i = 0; i < NQ; i++) sc_n[i] <= sb_n[i];
      sc_neg <= sb_neg;

      // rotated target rate/accel, gyroscopic torque
      for (int ax = 0; ax < 3; ax++) begin
        sd_wtb[ax] <= qsm_pkg::sat(qsm_pkg::wide_t'(sc_wt[ax]) + qsm_pkg::wide_t'(sc_nt[ax])
                      + qsm_pkg::wide_t'(qsm_pkg::sub2(sc_x2t[ax][0], sc_x2t[ax][1])));
        sd_wab[ax] <= qsm_pkg::sat(qsm_pkg::wide_t'(sc_wa[ax]) + qsm_pkg::wide_t'(sc_na[ax])
                      + qsm_pkg::wide_t'(qsm_pkg::sub2(sc_x2a[ax][0], sc_x2a[ax][1])));
        sd_gyro[ax] <= qsm_pkg::sub2(sc_g[ax][0], sc_g[ax][1]);
        sd_lq[ax] <= sc_lq[ax];
        sd_w[ax]  <= sc_w[ax];
      end
      for (int i = 0; i < NQ; i++) sd_n[i] <= sc_n[i];
      sd_neg <= sc_neg;

      // relative rate
      for (int ax = 0; ax < 3; ax++) begin
        se_we[ax]   <= qsm_pkg::sub2(sd_w[ax], sd_wtb[ax]);
        se_lq[ax]   <= sd_lq[ax];
        se_wtb[ax]  <= sd_wtb[ax];
        se_wab[ax]  <= sd_wab[ax];
        se_gyro[ax] <= sd_gyro[ax];
      end
      for (int i = 0; i < NQ; i++) se_n[i] <= sd_n[i];
      se_neg <= sd_neg;

      // surface, q_v dot products, feedforward cross products
      for (int ax = 0; ax < 3; ax++) begin
        sf_s[ax]  <= qsm_pkg::add2(se_we[ax], se_lq[ax]);
        sf_nw[ax] <= mulq(se_n[0], se_we[ax]);
        sf_xc[ax][0] <= mulq(se_n[qsm_pkg::nx1(ax)+1], se_we[qsm_pkg::nx2(ax)]);
        sf_xc[ax][1] <= mulq(se_n[qsm_pkg::nx2(ax)+1], se_we[qsm_pkg::nx1(ax)]);
        sf_xf[ax][0] <= mulq(se_we[qsm_pkg::nx1(ax)], se_wtb[qsm_pkg::nx2(ax)]);
        sf_xf[ax][1] <= mulq(se_we[qsm_pkg::nx2(ax)], se_wtb[qsm_pkg::nx1(ax)]);
        sf_wab[ax]  <= se_wab[ax];
        sf_gyro[ax] <= se_gyro[ax];
      end
      sf_neg <= se_neg;

      // q_ev dot, feedforward vector, boundary layer
      for (int ax = 0; ax < 3; ax++) begin
        sg_qd[ax] <= qsm_pkg::sat((qsm_pkg::wide_t'(sf_nw[ax])
                     + qsm_pkg::wide_t'(qsm_pkg::sub2(sf_xc[ax][0], sf_xc[ax][1]))
                     + qsm_pkg::wide_t'(1)) >>> 1);
        sg_ffv[ax] <= qsm_pkg::sub2(sf_wab[ax], qsm_pkg::sub2(sf_xf[ax][0], sf_xf[ax][1]));
        sg_x[ax]   <= clamp_one(qsm_pkg::gmul(inv_boundary, sf_s[ax]));
        sg_s[ax]    <= sf_s[ax];
        sg_gyro[ax] <= sf_gyro[ax];
      end
      sg_neg <= sf_neg;

      // equivalent and reaching vectors, I*ffv terms
      for (int ax = 0; ax < 3; ax++) begin
        sh_eqv[ax] <= qsm_pkg::neg_if(sg_neg, qsm_pkg::gmul(surface_gain, sg_qd[ax]));
        sh_r[ax]   <= qsm_pkg::gmul(reach_gain, sg_x[ax]);
        for (int k = 0; k < 3; k++) sh_ffp[ax][k] <= qsm_pkg::imt(inert[ax][k], sg_ffv[k]);
        sh_s[ax]    <= sg_s[ax];
        sh_gyro[ax] <= sg_gyro[ax];
      end

      for (int ax = 0; ax < 3; ax++) begin
        si_ff[ax] <= qsm_pkg::sum3(sh_ffp[ax][0], sh_ffp[ax][1], sh_ffp[ax][2]);
        for (int k = 0; k < 3; k++) begin
          si_eqp[ax][k] <= qsm_pkg::imt(inert[ax][k], sh_eqv[k]);
          si_rp[ax][k]  <= qsm_pkg::imt(inert[ax][k], sh_r[k]);
        end
        si_s[ax]    <= sh_s[ax];
        si_gyro[ax] <= sh_gyro[ax];
      end

      for (int ax = 0; ax < 3; ax++) begin
        sj_eq[ax]    <= qsm_pkg::sum3(si_eqp[ax][0], si_eqp[ax][1], si_eqp[ax][2]);
        sj_reach[ax] <= qsm_pkg::sum3(si_rp[ax][0], si_rp[ax][1], si_rp[ax][2]);
        sj_ff[ax]    <= si_ff[ax];
        sj_s[ax]     <= si_s[ax];
        sj_gyro[ax]  <= si_gyro[ax];
      end
    end
  end

  // torque sum, deadband, limit
  logic signed [15:0] tau_o [3];
  logic [2:0]         coast;
  always_comb begin
    qsm_pkg::val_t tau, lim;
    logic [31:0]   as;
    lim = qsm_pkg::val_t'({17'd0, torque_limit});
    for (int ax = 0; ax < 3; ax++) begin
      tau = qsm_pkg::sat(qsm_pkg::wide_t'(sj_gyro[ax]) + qsm_pkg::wide_t'(sj_ff[ax])
                       - qsm_pkg::wide_t'(sj_eq[ax]) - qsm_pkg::wide_t'(sj_reach[ax]));
      as = sj_s[ax][31] ? 32'(-sj_s[ax]) : 32'(sj_s[ax]);
      if (as < {16'd0, surface_deadband}) begin
        tau = '0;
        coast[ax] = 1'b1;
      end else begin
        coast[ax] = 1'b0;
        if (tau > lim) tau = lim;
        if (tau < -lim) tau = -lim;
      end
      tau_o[ax] = tau[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= {5'd0, coast, tau_o[2], tau_o[1], tau_o[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vn <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
      vj <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= sq_valid;
      vn <= dv_valid;
      va <= vn;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
      vi <= vh;
      vj <= vi;
      m_axis_tvalid <= vj;
    end
  end

endmodule

/* rtl/qsm_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module qsm_sqrt #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_rad,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [PW-1:0] out_pay
);

  localparam int NS = 32;

  logic          st_v [NS];
  logic [63:0]   st_n [NS];
  logic [63:0]   st_r [NS];
  logic [PW-1:0] st_p [NS];
  logic [63:0]   nx_n [NS];
  logic [63:0]   nx_r [NS];

  always_comb begin
    logic [63:0] sn, sr, bitv, cand;
    for (int g = 0; g < NS; g++) begin
      if (g == 0) begin
        sn = in_rad;
        sr = '0;
      end else begin
        sn = st_n[g-1];
        sr = st_r[g-1];
      end
      bitv = 64'd1 << (2 * (NS - 1 - g));
      cand = sr + bitv;
      if (sn >= cand) begin
        nx_n[g] = sn - cand;
        nx_r[g] = (sr >> 1) + bitv;
      end else begin
        nx_n[g] = sn;
        nx_r[g] = sr >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NS; g++) st_v[g] <= 1'b0;
    end else if (en) begin
      st_v[0] <= in_valid;
      for (int g = 1; g < NS; g++) st_v[g] <= st_v[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_p[0] <= in_pay;
      for (int g = 0; g < NS; g++) begin
        st_n[g] <= nx_n[g];
        st_r[g] <= nx_r[g];
      end
      for (int g = 1; g < NS; g++) st_p[g] <= st_p[g-1];
    end
  end

  assign out_valid = st_v[NS-1];
  assign out_root  = st_r[NS-1][31:0];
  assign out_pay   = st_p[NS-1];

endmodule

/* rtl/qsm_div.sv */
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage.
module qsm_div #(
  parameter int QW = 14,
  parameter int PW = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [qsm_pkg::QUAT_LEN-1:0][63:0]    in_num,
  input  logic [31:0]                           in_den,
  input  logic [PW-1:0]                         in_pay,
  output logic                                  out_valid,
  output logic [qsm_pkg::QUAT_LEN-1:0][QW-1:0]  out_quot,
  output logic [PW-1:0]                         out_pay
);

  localparam int NL = qsm_pkg::QUAT_LEN;

  logic          st_v   [QW];
  logic [31:0]   st_den [QW];
  logic [63:0]   st_rem [QW][NL];
  logic [QW-1:0] st_q   [QW][NL];
  logic [PW-1:0] st_p   [QW];
  logic [63:0]   nx_rem [QW][NL];
  logic [QW-1:0] nx_q   [QW][NL];

  always_comb begin
    logic [63:0]   sr, dsh;
    logic [QW-1:0] sq;
    logic [31:0]   sd;
    for (int g = 0; g < QW; g++) begin
      for (int l = 0; l < NL; l++) begin
        if (g == 0) begin
          sr = in_num[l];
          sq = '0;
          sd = in_den;
        end else begin
          sr = st_rem[g-1][l];
          sq = st_q[g-1][l];
          sd = st_den[g-1];
        end
        dsh = 64'(sd) << (QW - 1 - g);
        if (sr >= dsh) begin
          nx_rem[g][l] = sr - dsh;
          nx_q[g][l]   = sq | (QW'(1) << (QW - 1 - g));
        end else begin
          nx_rem[g][l] = sr;
          nx_q[g][l]   = sq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < QW; g++) st_v[g] <= 1'b0;
    end else if (en) begin
      st_v[0] <= in_valid;
      for (int g = 1; g < QW; g++) st_v[g] <= st_v[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_den[0] <= in_den;
      st_p[0]   <= in_pay;
      for (int g = 1; g < QW; g++) begin
        st_den[g] <= st_den[g-1];
        st_p[g]   <= st_p[g-1];
      end
      for (int g = 0; g < QW; g++) begin
        for (int l = 0; l < NL; l++) begin
          st_rem[g][l] <= nx_rem[g][l];
          st_q[g][l]   <= nx_q[g][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) out_quot[l] = st_q[QW-1][l];
  end

  assign out_valid = st_v[QW-1];
  assign out_pay   = st_p[QW-1];

endmodule
